@@ rtl/csh_pkg.sv @@
// Package for the case-folding string hash block.
// Holds payload structs, widths, shared-unit opcodes and the byte fold function.
// No dependencies.
package csh_pkg;

  localparam int INDEX_BITS = 24;
  localparam int HASH_W     = 32;
  localparam int CHAR_W     = 8;
  localparam int SH_W       = $clog2(HASH_W);
  localparam int CNT_W      = $clog2(HASH_W + 1);

  localparam logic [INDEX_BITS-1:0] TABLE_SIZE_RESET = INDEX_BITS'(10243);

  localparam logic [SH_W-1:0] SH_MIX_L = SH_W'(10);
  localparam logic [SH_W-1:0] SH_MIX_R = SH_W'(6);
  localparam logic [SH_W-1:0] SH_FIN_1 = SH_W'(3);
  localparam logic [SH_W-1:0] SH_FIN_2 = SH_W'(11);
  localparam logic [SH_W-1:0] SH_FIN_3 = SH_W'(15);

  localparam logic [CHAR_W-1:0] UPPER_A   = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] LOWER_A   = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_DIFF = 8'h20;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              is_last;
  } in_data_t;

  typedef struct packed {
    logic [HASH_W-1:0]     hash_value;
    logic [INDEX_BITS-1:0] bucket_index;
  } out_data_t;

  typedef enum logic [1:0] {
    OP_ADD_CHAR = 2'd0,
    OP_ADD_SHL  = 2'd1,
    OP_XOR_SHR  = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t         op;
    logic [SH_W-1:0] sh;
    logic            odd;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_sts_t;

  function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c,
                                                  input logic odd);
    logic [CHAR_W-1:0] f;
    f = c;
    if (f >= UPPER_A && f <= UPPER_Z) begin
      f = f + CASE_DIFF;
    end
    if (!odd && f >= LOWER_A && f <= LOWER_Z) begin
      f = f - CASE_DIFF;
    end
    return f;
  endfunction

endpackage

@@ rtl/csh_mix_alu.sv @@
// Shared mixing unit: add folded byte, add shifted-left, or xor shifted-right.
// Depends on csh_pkg.
module csh_mix_alu (
  input  csh_pkg::alu_ctl_t                 ctl,
  input  logic [csh_pkg::HASH_W-1:0]        h_in,
  input  logic [csh_pkg::CHAR_W-1:0]        char_byte,
  output logic [csh_pkg::HASH_W-1:0]        h_out
);
  import csh_pkg::*;

  logic [HASH_W-1:0] shl;
  logic [HASH_W-1:0] shr;
  logic [CHAR_W-1:0] folded;

  assign shl    = h_in << ctl.sh;
  assign shr    = h_in >> ctl.sh;
  assign folded = fold_byte(char_byte, ctl.odd);

  always_comb begin
    case (ctl.op)
      OP_ADD_CHAR: h_out = h_in + HASH_W'(folded);
      OP_ADD_SHL:  h_out = h_in + shl;
      OP_XOR_SHR:  h_out = h_in ^ shr;
      default:     h_out = h_in;
    endcase
  end

endmodule

@@ rtl/csh_mod_unit.sv @@
// Restoring modulo unit, one quotient bit per cycle.
// Depends on csh_pkg.
module csh_mod_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [csh_pkg::HASH_W-1:0]        dividend,
  input  logic [csh_pkg::INDEX_BITS-1:0]    divisor,
  output csh_pkg::mod_sts_t                 sts,
  output logic [csh_pkg::INDEX_BITS-1:0]    remainder
);
  import csh_pkg::*;

  logic [HASH_W-1:0]     dvd_r;
  logic [INDEX_BITS-1:0] rem_r;
  logic [INDEX_BITS-1:0] div_r;
  logic                  zero_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [INDEX_BITS:0]   sh;
  logic [INDEX_BITS:0]   diff;
  logic [INDEX_BITS-1:0] rem_nxt;

  assign sh      = {rem_r, dvd_r[HASH_W-1]};
  assign diff    = sh - {1'b0, div_r};
  assign rem_nxt = diff[INDEX_BITS] ? sh[INDEX_BITS-1:0] : diff[INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(HASH_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = zero_r ? '0 : rem_r;

endmodule

@@ rtl/case_folding_string_hash_bucket_top.sv @@
// Top level of the case-folding one-at-a-time string hash with bucket selection.
// Depends on csh_pkg, csh_mix_alu and csh_mod_unit.
//
// Keys enter one character per transaction; is_last ends the key. For each
// character a small sequencer runs the add and the two mixing steps through one
// shared shift/add/xor unit, one operation per cycle. After the last character it
// runs 3 avalanche steps on the same unit, then the bit-serial restoring modulo
// unit, and loads the result into an output register, so the next key may start
// while it waits. in_stall is high whenever the sequencer is not idle, and the
// sequencer holds a new result only while the previous one is not taken.
// table_size is written on cfg_we and must be changed only between keys; a value
// of zero gives bucket index 0.
module case_folding_string_hash_bucket_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  csh_pkg::in_data_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output csh_pkg::out_data_t              out_data,
  input  logic                            cfg_we,
  input  logic [csh_pkg::INDEX_BITS-1:0]  cfg_wdata
);
  import csh_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MIX1 = 8'b0000_0010,
    S_MIX2 = 8'b0000_0100,
    S_FIN1 = 8'b0000_1000,
    S_FIN2 = 8'b0001_0000,
    S_FIN3 = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_HOLD = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [HASH_W-1:0]     h_r;
  logic                  odd_r;
  logic                  last_r;
  logic [INDEX_BITS-1:0] table_size_r;
  logic                  out_valid_r;
  out_data_t             out_r;

  alu_ctl_t              alu_ctl;
  logic [HASH_W-1:0]     alu_out;
  logic                  mod_start;
  mod_sts_t              mod_sts;
  logic [INDEX_BITS-1:0] mod_rem;

  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_HOLD) && out_free;
  assign mod_start = (state_r == S_FIN3);

  csh_mix_alu u_alu (
    .ctl       (alu_ctl),
    .h_in      (h_r),
    .char_byte (in_data.char_byte),
    .h_out     (alu_out)
  );

  csh_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (alu_out),
    .divisor   (table_size_r),
    .sts       (mod_sts),
    .remainder (mod_rem)
  );

  always_comb begin
    alu_ctl.odd = odd_r;
    alu_ctl.op  = OP_ADD_CHAR;
    alu_ctl.sh  = '0;
    state_nxt   = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_MIX1;
        end
      end
      S_MIX1: begin
        alu_ctl.op = OP_ADD_SHL;
        alu_ctl.sh = SH_MIX_L;
        state_nxt  = S_MIX2;
      end
      S_MIX2: begin
        alu_ctl.op = OP_XOR_SHR;
        alu_ctl.sh = SH_MIX_R;
        state_nxt  = last_r ? S_FIN1 : S_IDLE;
      end
      S_FIN1: begin
        alu_ctl.op = OP_ADD_SHL;
        alu_ctl.sh = SH_FIN_1;
        state_nxt  = S_FIN2;
      end
      S_FIN2: begin
        alu_ctl.op = OP_XOR_SHR;
        alu_ctl.sh = SH_FIN_2;
        state_nxt  = S_FIN3;
      end
      S_FIN3: begin
        alu_ctl.op = OP_ADD_SHL;
        alu_ctl.sh = SH_FIN_3;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (mod_sts.done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      h_r          <= '0;
      odd_r        <= 1'b0;
      last_r       <= 1'b0;
      table_size_r <= TABLE_SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        table_size_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            h_r    <= alu_out;
            last_r <= in_data.is_last;
          end
        end
        S_MIX2: begin
          h_r <= alu_out;
          if (!last_r) begin
            odd_r <= !odd_r;
          end
        end
        S_MIX1, S_FIN1, S_FIN2, S_FIN3: h_r <= alu_out;
        S_HOLD: begin
          if (out_free) begin
            h_r   <= '0;
            odd_r <= 1'b0;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.hash_value   <= h_r;
      out_r.bucket_index <= mod_rem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    mod_sts.busy |-> in_stall)
    else $error("modulo unit busy while input open");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_sts.done |-> (state_r == S_DIV))
    else $error("modulo done outside divide state");

  a_odd_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX2 && !last_r) |=> (odd_r != $past(odd_r)))
    else $error("position parity not advanced");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");
`endif

endmodule

@@ test/case_folding_string_hash_bucket_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for case_folding_string_hash_bucket_top: streams keys one character per
// transaction, predicts hash and bucket of each key and checks every output transaction.
// Depends on csh_pkg and the RTL of the block.
module case_folding_string_hash_bucket_top_tb;
  import csh_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_data_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_data_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [INDEX_BITS-1:0] cfg_wdata = '0;

  int send_idle_pct  = 24;
  int recv_stall_pct = 77;
  int fail_count     = 0;
  int quiet_cycles   = 0;
  int chars_sent     = 0;

  logic [HASH_W-1:0]     key_hash     = '0;
  logic                  key_odd      = 1'b0;
  logic [INDEX_BITS-1:0] bucket_count = TABLE_SIZE_RESET;
  out_data_t             pending_hashes[$];
  out_data_t             head_hash;

  case_folding_string_hash_bucket_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hashes.size() == 0) begin
        $error("unexpected transaction: hash_value %h bucket_index %h",
               out_data.hash_value, out_data.bucket_index);
        fail_count++;
      end else begin
        head_hash = pending_hashes.pop_front();
        if (out_data.hash_value !== head_hash.hash_value) begin
          $error("hash_value: expected %h, actual %h",
                 head_hash.hash_value, out_data.hash_value);
          fail_count++;
        end
        if (out_data.bucket_index !== head_hash.bucket_index) begin
          $error("bucket_index: expected %h, actual %h",
                 head_hash.bucket_index, out_data.bucket_index);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic odd);
    logic [CHAR_W-1:0] f;
    f = c;
    if (f >= UPPER_A && f <= UPPER_Z) f = f + CASE_DIFF;
    if (!odd && f >= LOWER_A && f <= LOWER_Z) f = f - CASE_DIFF;
    return f;
  endfunction

  task automatic hash_accepted_char(input logic [CHAR_W-1:0] c, input logic last);
    logic [HASH_W-1:0] h;
    out_data_t         res;
    h = key_hash + HASH_W'(fold_char(c, key_odd));
    h = h + (h << 10);
    h = h ^ (h >> 6);
    if (!last) begin
      key_hash = h;
      key_odd  = ~key_odd;
    end else begin
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      res.hash_value   = h;
      res.bucket_index = (bucket_count == '0) ? '0
                       : INDEX_BITS'(h % HASH_W'(bucket_count));
      pending_hashes.push_back(res);
      key_hash = '0;
      key_odd  = 1'b0;
    end
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.char_byte <= c;
    in_data.is_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_accepted_char(c, last);
    chars_sent++;
  endtask

  task automatic send_key(input logic [CHAR_W-1:0] key[$]);
    foreach (key[i]) send_char(key[i], i == key.size() - 1);
  endtask

  function automatic logic [CHAR_W-1:0] random_char();
    case ($urandom_range(0, 3))
      0:       return CHAR_W'($urandom_range(8'h41, 8'h5A));
      1:       return CHAR_W'($urandom_range(8'h61, 8'h7A));
      2:       return CHAR_W'($urandom_range(8'h20, 8'h7E));
      default: return CHAR_W'($urandom());
    endcase
  endfunction

  task automatic send_random_key();
    logic [CHAR_W-1:0] key[$];
    int                len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
    repeat (len) key.push_back(random_char());
    send_key(key);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [INDEX_BITS-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    bucket_count = v;
  endtask

  // letter bounds and their neighbors, sent twice with a one-byte shift so each lands at even and odd positions
  task automatic test_case_folding();
    send_key('{8'h41, 8'h61, 8'h5A, 8'h7A, 8'h40, 8'h5B, 8'h60, 8'h7B});
    send_key('{8'h00, 8'h41, 8'h61, 8'h5A, 8'h7A, 8'h40, 8'h5B, 8'h60, 8'h7B});
  endtask

  task automatic test_raw_bytes();
    send_key('{8'h00});
    send_key('{8'hFF});
    send_key('{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00});
    send_key('{8'h61});
  endtask

  task automatic test_table_sizes();
    logic [INDEX_BITS-1:0] sizes[7];
    sizes = '{24'd1, 24'd2, 24'hFFFFFF, 24'd0, 24'h800000, 24'd10243, 24'd0};
    sizes[6] = INDEX_BITS'($urandom());
    foreach (sizes[i]) begin
      write_bucket_count(sizes[i]);
      repeat (4) send_random_key();
    end
  endtask

  task automatic test_random_keys(input int sender_pct, input int receiver_pct,
                                  input int count);
    int first;
    write_bucket_count(($urandom_range(0, 1) == 0) ?
                       INDEX_BITS'($urandom_range(1, 1000)) :
                       INDEX_BITS'($urandom_range(1, 24'hFFFFFF)));
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
    first = chars_sent;
    while (chars_sent - first < count) send_random_key();
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_case_folding();
    test_raw_bytes();
    test_table_sizes();
    test_random_keys(24, 77, 330);
    test_random_keys(77, 24, 330);
    test_random_keys(0, 0, 330);
    wait_idle();
    if (fail_count == 0 && pending_hashes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/csh_pkg.sv
rtl/csh_mix_alu.sv
rtl/csh_mod_unit.sv
rtl/case_folding_string_hash_bucket_top.sv
test/case_folding_string_hash_bucket_top_tb.sv
